>>> design/scanline_timer_line_interrupt_top_macros.svh
// assertion macros used by the top-level design file
`ifndef SCANLINE_TIMER_LINE_INTERRUPT_TOP_MACROS_SVH
`define SCANLINE_TIMER_LINE_INTERRUPT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SLTI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define SLTI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SLTI_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SLTI_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/slti_pkg.sv
package slti_pkg;

  localparam logic [9:0] CLOCKS_PER_LINE = 10'd684;
  localparam logic [8:0] LINES_NTSC      = 9'd262;
  localparam logic [8:0] LINES_PAL       = 9'd312;

  localparam logic [3:0] MODE_224 = 4'b1011;
  localparam logic [3:0] MODE_240 = 4'b1110;

  localparam logic [8:0] ACTIVE_192 = 9'd192;
  localparam logic [8:0] ACTIVE_224 = 9'd224;
  localparam logic [8:0] ACTIVE_240 = 9'd240;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_RELOAD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIDEO_MODE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_REGION   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_IRQ_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_IRQ_EN = 3'd4;

  typedef struct packed {
    logic [7:0] line_reload;
    logic [3:0] video_mode;
    logic       pal_region;
    logic       line_irq_enable;
    logic       frame_irq_enable;
  } cfg_t;

  typedef struct packed {
    logic tick;
    logic ack_line;
    logic ack_frame;
  } item_t;

  typedef struct packed {
    logic       irq;
    logic [9:0] hpos;
    logic [8:0] vpos;
    logic       in_vblank;
    logic       line_flag;
    logic       frame_flag;
  } res_t;

  function automatic logic [8:0] active_lines(input logic [3:0] mode);
    logic [8:0] act;
    case (mode)
      MODE_224: act = ACTIVE_224;
      MODE_240: act = ACTIVE_240;
      default:  act = ACTIVE_192;
    endcase
    return act;
  endfunction

endpackage

>>> design/slti_cfg_regs.sv
module slti_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [slti_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_data,
  output slti_pkg::cfg_t                   cfg
);
  import slti_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LINE_RELOAD:  cfg_r.line_reload      <= cfg_data;
        REG_VIDEO_MODE:   cfg_r.video_mode       <= cfg_data[3:0];
        REG_PAL_REGION:   cfg_r.pal_region       <= cfg_data[0];
        REG_LINE_IRQ_EN:  cfg_r.line_irq_enable  <= cfg_data[0];
        REG_FRAME_IRQ_EN: cfg_r.frame_irq_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/slti_in_reg.sv
module slti_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  slti_pkg::item_t in_item,
  output logic            in_stall,
  input  logic            adv,
  output logic            s1_valid,
  output slti_pkg::item_t s1_item
);
  import slti_pkg::*;

  logic  s1_valid_r;
  item_t s1_item_r;
  logic  accept;

  assign in_stall = s1_valid_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= in_item;
    end
  end

endmodule

>>> design/slti_timing.sv
module slti_timing (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  slti_pkg::item_t item,
  input  slti_pkg::cfg_t  cfg,
  output slti_pkg::res_t  res
);
  import slti_pkg::*;

  logic [9:0] hcount_r, hcount_nxt;
  logic [8:0] vcount_r, vcount_nxt;
  logic [7:0] line_down_r, line_down_nxt;
  logic       line_pending_r, line_pending_nxt;
  logic       frame_pending_r, frame_pending_nxt;

  logic [8:0] act;
  logic [8:0] frame_len;
  logic [9:0] hcount_inc;
  logic [8:0] vcount_inc;

  assign act        = active_lines(cfg.video_mode);
  assign frame_len  = cfg.pal_region ? LINES_PAL : LINES_NTSC;
  assign hcount_inc = hcount_r + 10'd1;
  assign vcount_inc = vcount_r + 9'd1;

  always_comb begin
    hcount_nxt        = hcount_r;
    vcount_nxt        = vcount_r;
    line_down_nxt     = line_down_r;
    line_pending_nxt  = line_pending_r && !item.ack_line;
    frame_pending_nxt = frame_pending_r && !item.ack_frame;

    if (item.tick) begin
      // line start work runs on the first clock of a line, before advancing
      if (hcount_r == '0) begin
        if (vcount_r <= act) begin
          if (line_down_r == '0) begin
            line_down_nxt    = cfg.line_reload;
            line_pending_nxt = 1'b1;
          end else begin
            line_down_nxt = line_down_r - 8'd1;
          end
        end else begin
          line_down_nxt = cfg.line_reload;
        end
        if (vcount_r == act + 9'd1) begin
          frame_pending_nxt = 1'b1;
        end
      end

      if (hcount_inc >= CLOCKS_PER_LINE) begin
        hcount_nxt = '0;
        // wraps on reach or pass, so a region switch late in a frame still wraps
        vcount_nxt = (vcount_inc >= frame_len) ? 9'd0 : vcount_inc;
      end else begin
        hcount_nxt = hcount_inc;
      end
    end
  end

  always_comb begin
    res.irq        = (cfg.line_irq_enable && line_pending_nxt) ||
                     (cfg.frame_irq_enable && frame_pending_nxt);
    res.hpos       = hcount_nxt;
    res.vpos       = vcount_nxt;
    res.in_vblank  = vcount_nxt >= act;
    res.line_flag  = line_pending_nxt;
    res.frame_flag = frame_pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcount_r        <= '0;
      vcount_r        <= '0;
      line_down_r     <= '0;
      line_pending_r  <= 1'b0;
      frame_pending_r <= 1'b0;
    end else if (fire) begin
      hcount_r        <= hcount_nxt;
      vcount_r        <= vcount_nxt;
      line_down_r     <= line_down_nxt;
      line_pending_r  <= line_pending_nxt;
      frame_pending_r <= frame_pending_nxt;
    end
  end

endmodule

>>> design/slti_out_reg.sv
module slti_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           s1_valid,
  input  slti_pkg::res_t res,
  output logic           adv,
  output logic           out_valid,
  input  logic           out_stall,
  output slti_pkg::res_t out_res
);
  import slti_pkg::*;

  logic out_valid_r;
  res_t out_res_r;

  // the result register takes a new item when empty or being drained
  assign adv       = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_res_r <= res;
    end
  end

endmodule

>>> design/scanline_timer_line_interrupt_top.sv
// Video H/V timing counter with line and frame interrupts. Each item is one
// pixel clock (tick=1) or an acknowledge-only update (tick=0); acks clear
// their flag before the tick is applied. One item is accepted per cycle while
// in_stall is low; it is held in the input register, and its result is
// captured in the result register, which drives the out_ ports, whenever
// that register can advance. The only thing that slows the rate is
// out_stall. hpos counts 0..683, vpos 0..261 (NTSC) or 0..311 (PAL). Write
// configuration only while no item is in flight.
module scanline_timer_line_interrupt_top (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_tick,
  input  logic                           in_ack_line,
  input  logic                           in_ack_frame,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_irq,
  output logic [9:0]                     out_hpos,
  output logic [8:0]                     out_vpos,
  output logic                           out_in_vblank,
  output logic                           out_line_flag,
  output logic                           out_frame_flag,

  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [slti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import slti_pkg::*;

  cfg_t  cfg;
  item_t in_item;
  item_t s1_item;
  res_t  res;
  res_t  out_res;
  logic  s1_valid;
  logic  adv;

  assign in_item.tick      = in_tick;
  assign in_item.ack_line  = in_ack_line;
  assign in_item.ack_frame = in_ack_frame;

  slti_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slti_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_item  (in_item),
    .in_stall (in_stall),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  slti_timing u_timing (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_valid && adv),
    .item  (s1_item),
    .cfg   (cfg),
    .res   (res)
  );

  slti_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_irq        = out_res.irq;
  assign out_hpos       = out_res.hpos;
  assign out_vpos       = out_res.vpos;
  assign out_in_vblank  = out_res.in_vblank;
  assign out_line_flag  = out_res.line_flag;
  assign out_frame_flag = out_res.frame_flag;

`include "scanline_timer_line_interrupt_top_macros.svh"

  `SLTI_ASSERT_IMP(a_stall_needs_item, clk, rst_n, in_stall, s1_valid)
  `SLTI_ASSERT_IMP(a_hpos_range, clk, rst_n, out_valid, out_hpos < CLOCKS_PER_LINE)
  `SLTI_ASSERT_IMP(a_irq_has_flag, clk, rst_n, out_valid && out_irq,
                   out_line_flag || out_frame_flag)
  `SLTI_ASSERT_IMP(a_active_not_vblank, clk, rst_n, out_valid && (out_vpos < ACTIVE_192),
                   !out_in_vblank)

endmodule
